[sv/mrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU request
// checker.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // crc-16, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // standard function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLAVE_ADDR   = 3'd0,
    CFG_ALT_ADDR     = 3'd1,
    CFG_ADDR_LOW     = 3'd2,
    CFG_ADDR_HIGH    = 3'd3,
    CFG_MAX_QTY      = 3'd4,
    CFG_READ_END     = 3'd5,
    CFG_WRITE_END    = 3'd6,
    CFG_EXTRA_FC     = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    V_READ_OK      = 4'd0,
    V_WSINGLE_OK   = 4'd1,
    V_WMULTI_OK    = 4'd2,
    V_EXTRA_OK     = 4'd3,
    V_NOT_ADDR     = 4'd4,
    V_ADDR_RANGE   = 4'd5,
    V_QTY          = 4'd6,
    V_CRC          = 4'd7,
    V_END_LIMIT    = 4'd8,
    V_BAD_FUNC     = 4'd9,
    V_LENGTH       = 4'd10
  } verdict_e;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  alt_slave_address;
    logic [15:0] addr_low;
    logic [15:0] addr_high;
    logic [15:0] max_quantity;
    logic [16:0] read_end_limit;
    logic [16:0] write_end_limit;
    logic [7:0]  extra_function_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [16:0] end_address;
    logic [15:0] echo_crc;
    logic [8:0]  frame_bytes;
  } out_t;

  // one byte through the crc, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/mrtu_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mrtu_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module mrtu_cfg_regs
  import mrtu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SLAVE_ADDR: cfg_d.slave_address       = cfg_data_i[7:0];
        CFG_ALT_ADDR:   cfg_d.alt_slave_address   = cfg_data_i[7:0];
        CFG_ADDR_LOW:   cfg_d.addr_low            = cfg_data_i[15:0];
        CFG_ADDR_HIGH:  cfg_d.addr_high           = cfg_data_i[15:0];
        CFG_MAX_QTY:    cfg_d.max_quantity        = cfg_data_i[15:0];
        CFG_READ_END:   cfg_d.read_end_limit      = cfg_data_i[16:0];
        CFG_WRITE_END:  cfg_d.write_end_limit     = cfg_data_i[16:0];
        CFG_EXTRA_FC:   cfg_d.extra_function_code = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address       <= 8'd1;
      cfg_q.alt_slave_address   <= 8'd0;
      cfg_q.addr_low            <= 16'd0;
      cfg_q.addr_high           <= 16'hFFFF;
      cfg_q.max_quantity        <= 16'd125;
      cfg_q.read_end_limit      <= 17'd65535;
      cfg_q.write_end_limit     <= 17'd65535;
      cfg_q.extra_function_code <= 8'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/mrtu_frame.sv]
// ----------------------------------------------------------------------------
// mrtu_frame
// Frame state (header, tail delay, running crc, byte count) and the verdict
// logic for the byte held in the input register.
// ----------------------------------------------------------------------------
module mrtu_frame
  import mrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic proc_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 2);
  localparam int unsigned FbW  = (CntW > 9) ? CntW : 9;

  logic [CntW-1:0] cnt_q, cnt_d, n;
  logic [15:0]     crc_q, crc_d, echo_q, echo_d;
  logic [7:0]      tail_q [2];
  logic [7:0]      tail_d [2];
  logic [7:0]      hdr_q  [6];
  logic [15:0]     crc_abs, crc_new, echo_new;
  logic [FbW-1:0]  n_ext;
  logic [7:0]      fc;
  logic [15:0]     start, qty;
  logic [16:0]     end_addr;
  logic            len_bad;
  verdict_e        verdict;

  // oldest delayed byte enters the crc once two bytes are behind it
  assign crc_abs  = crc16_byte(crc_q, tail_q[0]);
  assign crc_new  = (cnt_q >= CntW'(2)) ? crc_abs : crc_q;
  assign echo_new = (cnt_q == CntW'(7)) ? crc_abs : echo_q;
  assign n        = (cnt_q <= CntW'(MAX_FRAME)) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    if (item_i.last_byte) begin
      crc_d     = CRC_INIT;
      echo_d    = 16'h0000;
      tail_d[0] = 8'h00;
      tail_d[1] = 8'h00;
      cnt_d     = '0;
    end else begin
      crc_d     = crc_new;
      echo_d    = echo_new;
      tail_d[0] = tail_q[1];
      tail_d[1] = item_i.rx_byte;
      cnt_d     = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      crc_q     <= CRC_INIT;
      echo_q    <= 16'h0000;
      tail_q[0] <= 8'h00;
      tail_q[1] <= 8'h00;
    end else if (proc_i) begin
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      echo_q    <= echo_d;
      tail_q[0] <= tail_d[0];
      tail_q[1] <= tail_d[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i && (cnt_q < CntW'(6))) begin
      hdr_q[cnt_q[2:0]] <= item_i.rx_byte;
    end
  end

  assign fc       = hdr_q[1];
  assign start    = {hdr_q[2], hdr_q[3]};
  assign qty      = {hdr_q[4], hdr_q[5]};
  assign end_addr = {1'b0, start} + {1'b0, qty};
  assign len_bad  = (n < CntW'(8)) || (n > CntW'(MAX_FRAME));
  assign n_ext    = FbW'(n);

  always_comb begin
    if (len_bad) begin
      verdict = V_LENGTH;
    end else if ((hdr_q[0] != cfg_i.slave_address) && (hdr_q[0] != cfg_i.alt_slave_address)) begin
      verdict = V_NOT_ADDR;
    end else if ((start < cfg_i.addr_low) || (start > cfg_i.addr_high)) begin
      verdict = V_ADDR_RANGE;
    end else if (qty > cfg_i.max_quantity) begin
      verdict = V_QTY;
    end else if ((tail_q[1] != crc_new[7:0]) || (item_i.rx_byte != crc_new[15:8])) begin
      verdict = V_CRC;
    end else if (fc == FC_READ_HOLDING) begin
      verdict = (end_addr > cfg_i.read_end_limit) ? V_END_LIMIT : V_READ_OK;
    end else if (fc == FC_WRITE_SINGLE) begin
      verdict = V_WSINGLE_OK;
    end else if (fc == FC_WRITE_MULTI) begin
      verdict = (end_addr > cfg_i.write_end_limit) ? V_END_LIMIT : V_WMULTI_OK;
    end else if (fc == cfg_i.extra_function_code) begin
      verdict = V_EXTRA_OK;
    end else begin
      verdict = V_BAD_FUNC;
    end
  end

  // an eight-byte frame takes its echo crc on the last byte itself
  always_comb begin
    res_o.verdict       = verdict;
    res_o.function_code = len_bad ? 8'h00 : fc;
    res_o.start_address = len_bad ? 16'h0000 : start;
    res_o.quantity      = len_bad ? 16'h0000 : qty;
    res_o.end_address   = len_bad ? 17'h00000 : end_addr;
    res_o.echo_crc      = len_bad ? 16'h0000 : echo_new;
    res_o.frame_bytes   = (n_ext > FbW'(511)) ? 9'd511 : n_ext[8:0];
  end

`ifndef SYNTHESIS
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && item_i.last_byte) |=> (cnt_q == '0) && (crc_q == CRC_INIT))
    else $error("frame state not cleared after last byte");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_FRAME + 1))
    else $error("byte count past saturation");
`endif

endmodule

[sv/modbus_rtu_request_checker.sv]
// path: a byte is taken into the input register and updates the frame state from
// there; its result (on the last byte only) is registered in the output register
// throughput: one byte per cycle, unless a last byte waits on a stalled result
// reset: configuration takes its defaults, frame state is cleared at once
// ----------------------------------------------------------------------------
// modbus_rtu_request_checker
// Byte-wise Modbus RTU request checker: header capture, crc-16 check and a
// single verdict per frame on the last-byte beat.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker
  import mrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  out_t res;

  // input register
  logic in_valid_q;
  in_t  in_data_q;
  // output register
  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  logic proc;   // byte in the input register updates the frame this cycle
  logic load;   // new input beat taken

  mrtu_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  mrtu_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk_i,
    .rst_ni,
    .proc_i (proc),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // only a last byte needs the output register; it waits while a stalled
  // result still sits there, any other byte always moves on
  assign proc       = in_valid_q && (!in_data_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_data_q <= in_data_i;
    end
  end

  // result register: filled by a processed last byte, held while stalled
  assign out_valid_d = (proc && in_data_q.last_byte) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_data_q.last_byte) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_data_q.last_byte && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(proc && in_data_q.last_byte) && !(out_valid_q && out_stall_i)) |=> !out_valid_o)
    else $error("result beat without a last byte");

  a_length_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.verdict == V_LENGTH)) |->
      ((out_data_o.function_code == 8'h00) && (out_data_o.echo_crc == 16'h0000)))
    else $error("length verdict carries header data");
`endif

endmodule

[bench/mrtu_verdict_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrtu_verdict_checker
// Watches the byte, verdict and register ports of the request checker,
// rebuilds every frame verdict on its own and compares it field by field.
// ----------------------------------------------------------------------------
module mrtu_verdict_checker
  import mrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  cfg_t        regs;
  logic [15:0] crc_acc;
  logic [7:0]  hdr [6];
  logic [7:0]  tail [2];
  logic [15:0] echo_snap;
  int unsigned nbytes;
  out_t        verdict_q [$];
  int          fails;

  task automatic clear_frame();
    crc_acc   = 16'hFFFF;
    hdr       = '{default: 8'h00};
    tail      = '{default: 8'h00};
    echo_snap = 16'h0000;
    nbytes    = 0;
  endtask

  task automatic compare_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t        exp_r;
    logic [7:0]  b;
    int unsigned n;
    logic [15:0] start_a;
    logic [15:0] qty_a;
    logic [16:0] stop;
    if (!rst_ni) begin
      regs = '{8'd1, 8'd0, 16'd0, 16'hFFFF, 16'd125, 17'd65535, 17'd65535, 8'd100};
      clear_frame();
      verdict_q.delete();
      fails = 0;
    end else begin
      // a result never leaves at the edge that takes its last byte, so check first
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict beat with nothing expected, actual verdict %0d",
                   $time, out_data_i.verdict);
          fails++;
        end else begin
          exp_r = verdict_q.pop_front();
          compare_field("verdict", exp_r.verdict, out_data_i.verdict);
          compare_field("function_code", exp_r.function_code, out_data_i.function_code);
          compare_field("start_address", exp_r.start_address, out_data_i.start_address);
          compare_field("quantity", exp_r.quantity, out_data_i.quantity);
          compare_field("end_address", exp_r.end_address, out_data_i.end_address);
          compare_field("echo_crc", exp_r.echo_crc, out_data_i.echo_crc);
          compare_field("frame_bytes", exp_r.frame_bytes, out_data_i.frame_bytes);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SLAVE_ADDR: regs.slave_address       = cfg_data_i[7:0];
          CFG_ALT_ADDR:   regs.alt_slave_address   = cfg_data_i[7:0];
          CFG_ADDR_LOW:   regs.addr_low            = cfg_data_i[15:0];
          CFG_ADDR_HIGH:  regs.addr_high           = cfg_data_i[15:0];
          CFG_MAX_QTY:    regs.max_quantity        = cfg_data_i[15:0];
          CFG_READ_END:   regs.read_end_limit      = cfg_data_i[16:0];
          CFG_WRITE_END:  regs.write_end_limit     = cfg_data_i[16:0];
          CFG_EXTRA_FC:   regs.extra_function_code = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        b = in_data_i.rx_byte;
        // the oldest delayed byte joins the crc, the final two never do
        if (nbytes >= 2 && nbytes <= MAX_FRAME + 1) begin
          for (int i = 0; i < 8; i++) begin
            crc_acc = (crc_acc[0] ^ tail[0][i]) ? ((crc_acc >> 1) ^ 16'hA001)
                                                : (crc_acc >> 1);
          end
          if (nbytes == 7) echo_snap = crc_acc;
        end
        if (nbytes < 6) hdr[nbytes] = b;

        if (!in_data_i.last_byte) begin
          tail[0] = tail[1];
          tail[1] = b;
          if (nbytes <= MAX_FRAME) nbytes++;
        end else begin
          n = (nbytes <= MAX_FRAME) ? nbytes + 1 : nbytes;
          exp_r = '0;
          exp_r.frame_bytes = (n > 511) ? 9'd511 : 9'(n);
          if (n < 8 || n > MAX_FRAME) begin
            exp_r.verdict = V_LENGTH;
          end else begin
            start_a = {hdr[2], hdr[3]};
            qty_a   = {hdr[4], hdr[5]};
            stop    = 17'(start_a) + 17'(qty_a);
            if (hdr[0] != regs.slave_address && hdr[0] != regs.alt_slave_address)
              exp_r.verdict = V_NOT_ADDR;
            else if (start_a < regs.addr_low || start_a > regs.addr_high)
              exp_r.verdict = V_ADDR_RANGE;
            else if (qty_a > regs.max_quantity)
              exp_r.verdict = V_QTY;
            else if (tail[1] != crc_acc[7:0] || b != crc_acc[15:8])
              exp_r.verdict = V_CRC;
            else if (hdr[1] == FC_READ_HOLDING)
              exp_r.verdict = (stop > regs.read_end_limit) ? V_END_LIMIT : V_READ_OK;
            else if (hdr[1] == FC_WRITE_SINGLE)
              exp_r.verdict = V_WSINGLE_OK;
            else if (hdr[1] == FC_WRITE_MULTI)
              exp_r.verdict = (stop > regs.write_end_limit) ? V_END_LIMIT : V_WMULTI_OK;
            else if (hdr[1] == regs.extra_function_code)
              exp_r.verdict = V_EXTRA_OK;
            else
              exp_r.verdict = V_BAD_FUNC;
            exp_r.function_code = hdr[1];
            exp_r.start_address = start_a;
            exp_r.quantity      = qty_a;
            exp_r.end_address   = stop;
            exp_r.echo_crc      = echo_snap;
          end
          verdict_q.push_back(exp_r);
          clear_frame();
        end
      end
    end
    pending_o    <= verdict_q.size();
    fail_count_o <= fails;
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds Modbus RTU request frames byte by byte into the request checker:
// a few hand-built frames, then phases of mostly well-formed random requests
// under changing register settings, with random gaps and stalls on both
// channels. The verdict checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mrtu_pkg::*;

  localparam int unsigned FrameMax   = 256;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseBytes = 125;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // quiet turns off random gaps and stalls on both sides
  logic quiet   = 1'b0;
  // asks the receiver for its one long hold-off
  logic hold_go = 1'b0;

  int          pending;
  int          fail_count;
  int unsigned bytes_sent = 0;
  cfg_t        settings;

  modbus_rtu_request_checker #(
    .MAX_FRAME (FrameMax)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mrtu_verdict_checker #(
    .MAX_FRAME (FrameMax)
  ) verdict_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one byte beat; random gaps before it unless quiet, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // random bytes, last marker on the final one
  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // header, optional payload, crc low byte first; crc can be spoiled
  task automatic send_request(input logic [7:0] addr, input logic [7:0] fc,
                              input logic [15:0] start, input logic [15:0] qty,
                              input int payload, input bit bad_crc);
    logic [7:0]  fr [$];
    logic [15:0] crc;
    fr = '{addr, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    repeat (payload) fr.push_back(8'($urandom_range(255)));
    crc = CRC_INIT;
    foreach (fr[i]) crc = crc16_byte(crc, fr[i]);
    if (bad_crc) crc ^= 16'($urandom_range(16'hFFFF, 1));
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // mostly well-formed requests aimed at the current settings, some noise
  task automatic send_random_frame();
    int          r;
    logic [7:0]  addr;
    logic [7:0]  fc;
    logic [15:0] start;
    logic [15:0] qty;
    r = $urandom_range(99);
    if (r < 12) begin
      // too short for any request
      send_noise($urandom_range(7, 1));
    end else if (r < 18) begin
      send_noise($urandom_range(20, 8));
    end else begin
      r = $urandom_range(9);
      if (r < 7) addr = settings.slave_address;
      else if (r < 9) addr = settings.alt_slave_address;
      else addr = 8'($urandom);

      r = $urandom_range(9);
      if (r < 3) fc = FC_READ_HOLDING;
      else if (r < 5) fc = FC_WRITE_SINGLE;
      else if (r < 7) fc = FC_WRITE_MULTI;
      else if (r == 7) fc = settings.extra_function_code;
      else fc = 8'($urandom);

      // start inside the window, at the extremes, or anywhere
      r = $urandom_range(9);
      if (r == 7) start = 16'h0000;
      else if (r == 8) start = 16'hFFFF;
      else if (r == 9 || settings.addr_low > settings.addr_high) start = 16'($urandom);
      else start = 16'($urandom_range(settings.addr_high, settings.addr_low));

      r = $urandom_range(9);
      if (r == 7) qty = 16'h0000;
      else if (r == 8) qty = 16'hFFFF;
      else if (r == 9) qty = 16'($urandom);
      else qty = 16'($urandom_range(settings.max_quantity, 0));

      send_request(addr, fc, start, qty,
                   ($urandom_range(3) == 0) ? $urandom_range(12, 1) : 0,
                   $urandom_range(9) == 0);
    end
  endtask

  // register writes; load_settings puts junk above each register's width where the port is wider
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    settings = s;
    write_reg(CFG_SLAVE_ADDR, {9'($urandom), s.slave_address});
    write_reg(CFG_ALT_ADDR,   {9'($urandom), s.alt_slave_address});
    write_reg(CFG_ADDR_LOW,   {1'($urandom), s.addr_low});
    write_reg(CFG_ADDR_HIGH,  {1'($urandom), s.addr_high});
    write_reg(CFG_MAX_QTY,    {1'($urandom), s.max_quantity});
    write_reg(CFG_READ_END,   s.read_end_limit);
    write_reg(CFG_WRITE_END,  s.write_end_limit);
    write_reg(CFG_EXTRA_FC,   {9'($urandom), s.extra_function_code});
    cfg_we <= 1'b0;
  endtask

  // sender stops until every verdict is in, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 29);
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    cfg_t        plan [6];
    logic [15:0] lo;
    int unsigned goal;

    // reset defaults, a middle setting, both extremes, then two random ones
    plan[0] = '{8'd1, 8'd0, 16'd0, 16'hFFFF, 16'd125, 17'd65535, 17'd65535, 8'd100};
    plan[1] = '{8'h11, 8'hFF, 16'h0010, 16'h8000, 16'd200, 17'h01000, 17'h09000, 8'h41};
    // extra code collides with read holding, the standard meaning wins
    plan[2] = '{8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 17'd131070, 17'd131070,
                FC_READ_HOLDING};
    plan[3] = '{8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0, FC_WRITE_MULTI};
    lo = 16'($urandom_range(32767));
    plan[4] = '{8'($urandom), 8'($urandom), lo, 16'($urandom_range(65535, lo)),
                16'($urandom_range(300)), 17'($urandom_range(131070)),
                17'($urandom_range(131070)), FC_WRITE_SINGLE};
    plan[5] = '{8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 17'($urandom_range(131070)),
                17'($urandom_range(131070)), 8'($urandom)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings = plan[0];

    // hand-built frames under the reset settings
    send_request(8'd1, FC_READ_HOLDING, 16'h0000, 16'd125, 0, 1'b0);
    send_noise(1);
    // write single at the top address, end beyond 16 bits is not checked
    send_request(8'd0, FC_WRITE_SINGLE, 16'hFFFF, 16'd125, 0, 1'b0);
    send_noise(7);
    drain();

    for (int p = 0; p < 6; p++) begin
      load_settings(plan[p]);
      quiet <= (p == 3);
      goal = bytes_sent + PhaseBytes;
      if (p == 1) begin
        // receiver holds off while short frames keep coming in
        hold_go <= 1'b1;
        repeat (12) send_random_frame();
      end
      // longest legal frame, and one past the byte count saturation
      if (p == 2)
        send_request(settings.slave_address, FC_READ_HOLDING, 16'h0000, 16'd0,
                     FrameMax - 8, 1'b0);
      if (p == 4)
        send_request(settings.slave_address, FC_WRITE_MULTI, settings.addr_low, 16'd1,
                     FrameMax - 6, 1'b0);
      while (bytes_sent < goal) send_random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/mrtu_pkg.sv
sv/mrtu_cfg_regs.sv
sv/mrtu_frame.sv
sv/modbus_rtu_request_checker.sv
bench/mrtu_verdict_checker.sv
bench/tb_top.sv
